// ===== hdl/bmhq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package bmhq_pkg;

   localparam int KEY_W    = 32;
   localparam int COUNT_W  = 11;
   localparam int STATUS_W = 2;

   typedef logic signed [KEY_W-1:0] key_type;
   typedef logic [COUNT_W-1:0]      count_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   localparam logic KIND_INSERT = 1'b0;
   localparam logic KIND_DELETE = 1'b1;

   localparam count_type CAPACITY_RESET = 11'd1024;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INS_START,
      ST_INS_CMP,
      ST_DEL_TOP,
      ST_DEL_MOVED,
      ST_DEL_LEFT,
      ST_DEL_RIGHT,
      ST_DEL_DEC,
      ST_WR_KEY,
      ST_DONE
   } state_type;

endpackage
`default_nettype wire

// ===== hdl/bmhq_req_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface bmhq_req_if;
   import bmhq_pkg::*;

   logic    valid;
   logic    ready;
   logic    kind;
   key_type key_in;

   modport source (output valid, output kind, output key_in, input ready);
   modport sink (input valid, input kind, input key_in, output ready);
endinterface
`default_nettype wire

// ===== hdl/bmhq_rsp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface bmhq_rsp_if;
   import bmhq_pkg::*;

   logic       valid;
   logic       ready;
   key_type    min_out;
   status_type status;
   count_type  count;

   modport source (output valid, output min_out, output status, output count, input ready);
   modport sink (input valid, input min_out, input status, input count, output ready);
endinterface
`default_nettype wire

// ===== hdl/bmhq_csr_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface bmhq_csr_if;
   import bmhq_pkg::*;

   logic      valid;
   logic      ready;
   count_type capacity;

   modport source (output valid, output capacity, input ready);
   modport sink (input valid, input capacity, output ready);
endinterface
`default_nettype wire

// ===== hdl/bmhq_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module bmhq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== hdl/binary_min_heap_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Min-heap priority queue of signed 32-bit keys, held in one dual-port RAM.
// req_chan carries a request: kind 0 inserts key_in, kind 1 removes and returns
// the smallest key. rsp_chan returns one response per request: min_out (the
// removed key, else 0), status (ok, full, empty) and count (keys held after).
// csr_chan writes the capacity register (reset 1024, clamped to DEPTH); write it
// only while no request is in flight.
// One request is worked at a time; req_chan.ready is low until it finishes.
// Insert: ST_INS_START reads the parent, ST_INS_CMP runs once per level the key
// climbs, ST_WR_KEY writes it if it reaches the root, ST_DONE loads the
// output register. Delete: ST_DEL_TOP, ST_DEL_MOVED, then per level compared
// ST_DEL_LEFT (left read), ST_DEL_RIGHT (right read) and ST_DEL_DEC (compare),
// plus ST_WR_KEY when the key sinks to a leaf. Refused requests go straight to
// ST_DONE. The next request is accepted in the cycle after the response is
// loaded. Pace is set by the single RAM read port and one shared key comparator.
// A finished response waits in the output register; the next request is
// accepted meanwhile and only its completion waits on rsp_chan.ready.
// Reset (synchronous) empties the heap, sets capacity to 1024 and drops any
// pending response. RAM contents are not cleared.
module binary_min_heap_queue #(
   parameter int DEPTH = 1024
) (
   input  wire logic  clock,
   input  wire logic  reset,
   bmhq_req_if.sink   req_chan,
   bmhq_rsp_if.source rsp_chan,
   bmhq_csr_if.sink   csr_chan
);
   import bmhq_pkg::*;

   localparam int ADDR_W = $clog2(DEPTH);
   localparam int FILL_W = $clog2(DEPTH + 1);
   localparam int KID_W  = ADDR_W + 1;
   localparam int CMP_W  = (FILL_W > COUNT_W) ? FILL_W : COUNT_W;

   state_type   state_ff, state_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   count_type   capacity_ff;
   logic [ADDR_W-1:0] slot_ff, slot_in;
   logic [ADDR_W-1:0] up_ff, up_in;
   key_type     key_ff, key_in_nxt;
   key_type     kid_ff, kid_in;
   key_type     top_ff, top_in;
   status_type  status_ff, status_in;

   logic        rsp_valid_ff, rsp_valid_in;
   key_type     rsp_min_ff, rsp_min_in;
   status_type  rsp_status_ff, rsp_status_in;
   count_type   rsp_count_ff, rsp_count_in;

   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   key_type           wr_data;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic [KEY_W-1:0]  rd_raw;
   key_type           rd_key;

   key_type cmp_a;
   key_type cmp_b;
   logic    cmp_gt;

   logic              req_fire;
   logic              is_full;
   logic              out_free;
   logic [ADDR_W-1:0] up_parent;
   logic [ADDR_W-1:0] slot_parent;
   logic [KID_W-1:0]  fill_kid;
   logic [KID_W-1:0]  right_kid;
   logic [KID_W-1:0]  next_left;

   bmhq_ram #(
      .WIDTH(KEY_W),
      .DEPTH(DEPTH)
   ) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_raw)
   );

   assign rd_key = $signed(rd_raw);

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_fire       = req_chan.valid && (state_ff == ST_IDLE);
   assign csr_chan.ready = 1'b1;

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.min_out = rsp_min_ff;
   assign rsp_chan.status  = rsp_status_ff;
   assign rsp_chan.count   = rsp_count_ff;

   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   // capacity above DEPTH behaves as DEPTH, and fill never exceeds DEPTH
   assign is_full = (CMP_W'(fill_ff) >= CMP_W'(capacity_ff))
                 || (fill_ff == FILL_W'(DEPTH));

   assign slot_parent = (slot_ff - 1'b1) >> 1;
   assign up_parent   = (up_ff - 1'b1) >> 1;
   assign fill_kid    = KID_W'(fill_ff);
   assign right_kid   = KID_W'(up_ff) + 1'b1;
   assign next_left   = {up_ff, 1'b1};

   // the one shared key comparator: cmp_a > cmp_b
   always_comb begin
      case (state_ff)
         ST_INS_CMP: begin
            cmp_a = rd_key;
            cmp_b = key_ff;
         end
         ST_DEL_RIGHT: begin
            cmp_a = kid_ff;
            cmp_b = rd_key;
         end
         default: begin
            cmp_a = key_ff;
            cmp_b = kid_ff;
         end
      endcase
   end

   assign cmp_gt = cmp_a > cmp_b;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_chan.kind == KIND_INSERT) begin
                  state_in = is_full ? ST_DONE : ST_INS_START;
               end else begin
                  state_in = (fill_ff == '0) ? ST_DONE : ST_DEL_TOP;
               end
            end
         end
         ST_INS_START: begin
            state_in = (slot_ff == '0) ? ST_DONE : ST_INS_CMP;
         end
         ST_INS_CMP: begin
            if (!cmp_gt) begin
               state_in = ST_DONE;
            end else if (up_ff == '0) begin
               state_in = ST_WR_KEY;
            end
         end
         ST_DEL_TOP: begin
            state_in = ST_DEL_MOVED;
         end
         ST_DEL_MOVED: begin
            state_in = (fill_ff > FILL_W'(1)) ? ST_DEL_LEFT : ST_DONE;
         end
         ST_DEL_LEFT: begin
            state_in = (right_kid < fill_kid) ? ST_DEL_RIGHT : ST_DEL_DEC;
         end
         ST_DEL_RIGHT: begin
            state_in = ST_DEL_DEC;
         end
         ST_DEL_DEC: begin
            if (!cmp_gt) begin
               state_in = ST_DONE;
            end else if (next_left < fill_kid) begin
               state_in = ST_DEL_LEFT;
            end else begin
               state_in = ST_WR_KEY;
            end
         end
         ST_WR_KEY: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // datapath and memory control
   always_comb begin
      fill_in       = fill_ff;
      slot_in       = slot_ff;
      up_in         = up_ff;
      key_in_nxt    = key_ff;
      kid_in        = kid_ff;
      top_in        = top_ff;
      status_in     = status_ff;
      wr_en         = 1'b0;
      wr_addr       = slot_ff;
      wr_data       = key_ff;
      rd_en         = 1'b0;
      rd_addr       = '0;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_min_in    = rsp_min_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;

      case (state_ff)
         ST_IDLE: begin
            // root read is issued speculatively for a delete
            rd_en = 1'b1;
            if (req_fire) begin
               key_in_nxt = req_chan.key_in;
               top_in     = '0;
               status_in  = STATUS_OK;
               if (req_chan.kind == KIND_INSERT) begin
                  if (is_full) begin
                     status_in = STATUS_FULL;
                  end else begin
                     slot_in = ADDR_W'(fill_ff);
                     fill_in = fill_ff + 1'b1;
                  end
               end else begin
                  if (fill_ff == '0) begin
                     status_in = STATUS_EMPTY;
                  end else begin
                     fill_in = fill_ff - 1'b1;
                  end
               end
            end
         end
         ST_INS_START: begin
            if (slot_ff == '0) begin
               wr_en = 1'b1;
            end else begin
               rd_en   = 1'b1;
               rd_addr = slot_parent;
               up_in   = slot_parent;
            end
         end
         ST_INS_CMP: begin
            wr_en = 1'b1;
            if (cmp_gt) begin
               // parent moves down into the hole, key keeps climbing
               wr_data = rd_key;
               slot_in = up_ff;
               rd_en   = 1'b1;
               rd_addr = up_parent;
               up_in   = up_parent;
            end
         end
         ST_DEL_TOP: begin
            top_in  = rd_key;
            rd_en   = 1'b1;
            rd_addr = ADDR_W'(fill_ff);
         end
         ST_DEL_MOVED: begin
            key_in_nxt = rd_key;
            slot_in    = '0;
            if (fill_ff > FILL_W'(1)) begin
               rd_en   = 1'b1;
               rd_addr = ADDR_W'(1);
               up_in   = ADDR_W'(1);
            end else begin
               wr_en   = 1'b1;
               wr_addr = '0;
               wr_data = rd_key;
            end
         end
         ST_DEL_LEFT: begin
            kid_in = rd_key;
            if (right_kid < fill_kid) begin
               rd_en   = 1'b1;
               rd_addr = ADDR_W'(right_kid);
            end
         end
         ST_DEL_RIGHT: begin
            // left wins ties
            if (cmp_gt) begin
               kid_in = rd_key;
               up_in  = ADDR_W'(right_kid);
            end
         end
         ST_DEL_DEC: begin
            wr_en = 1'b1;
            if (cmp_gt) begin
               wr_data = kid_ff;
               slot_in = up_ff;
               if (next_left < fill_kid) begin
                  rd_en   = 1'b1;
                  rd_addr = ADDR_W'(next_left);
                  up_in   = ADDR_W'(next_left);
               end
            end
         end
         ST_WR_KEY: begin
            wr_en = 1'b1;
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_min_in    = top_ff;
               rsp_status_in = status_ff;
               rsp_count_in  = COUNT_W'(fill_ff);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         capacity_ff  <= CAPACITY_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_chan.valid) begin
            capacity_ff <= csr_chan.capacity;
         end
      end
   end

   always_ff @(posedge clock) begin
      slot_ff       <= slot_in;
      up_ff         <= up_in;
      key_ff        <= key_in_nxt;
      kid_ff        <= kid_in;
      top_ff        <= top_in;
      status_ff     <= status_in;
      rsp_min_ff    <= rsp_min_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

endmodule
`default_nettype wire

// ===== hdl/bmhq_chk.sv =====
`timescale 1ns / 1ps
`default_nettype none
module bmhq_chk (
   input wire logic                      clock,
   input wire logic                      reset,
   input wire logic                      req_valid,
   input wire logic                      req_ready,
   input wire logic                      rsp_valid,
   input wire logic                      rsp_ready,
   input wire logic [bmhq_pkg::KEY_W-1:0]    rsp_min_out,
   input wire logic [bmhq_pkg::STATUS_W-1:0] rsp_status,
   input wire logic [bmhq_pkg::COUNT_W-1:0]  rsp_count
);
   import bmhq_pkg::*;

   // a pending response stays until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // req_ready drops once a request is accepted
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while busy");

   a_refused_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != STATUS_OK) |-> rsp_min_out == '0)
      else $error("refused request returned a key");

   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_EMPTY) |-> rsp_count == '0)
      else $error("empty status with nonzero count");

endmodule

bind binary_min_heap_queue bmhq_chk u_bmhq_chk (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_chan.valid),
   .req_ready  (req_chan.ready),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .rsp_min_out(rsp_chan.min_out),
   .rsp_status (rsp_chan.status),
   .rsp_count  (rsp_chan.count)
);
`default_nettype wire

// ===== test/heap_checker.sv =====
`timescale 1ns / 1ps
module heap_checker #(
   parameter int DEPTH = 1024
) (
   input  wire logic clock,
   input  wire logic reset,
   bmhq_req_if       req_mon,
   bmhq_rsp_if       rsp_mon,
   bmhq_csr_if       csr_mon,
   output int        fail_count,
   output int        waiting
);
   import bmhq_pkg::*;

   typedef struct {
      key_type    min_out;
      status_type status;
      count_type  count;
   } heap_result_t;

   key_type      heap_keys [DEPTH];
   int unsigned  held;
   count_type    cap_reg;
   heap_result_t expected_q [$];
   heap_result_t want;
   int           errors = 0;
   int           outstanding = 0;

   assign fail_count = errors;
   assign waiting    = outstanding;

   task automatic report_error(string msg);
      $display("%0t heap_checker: %s", $time, msg);
      errors++;
   endtask

   function automatic int unsigned cap_limit();
      return (cap_reg > DEPTH) ? DEPTH : cap_reg;
   endfunction

   // sift up while the parent is strictly greater
   function automatic void push_key(key_type key);
      int unsigned slot;
      int unsigned up;
      bit          climbing;
      slot     = held;
      climbing = 1'b1;
      while (climbing && slot > 0) begin
         up = (slot - 1) / 2;
         if (heap_keys[up] > key) begin
            heap_keys[slot] = heap_keys[up];
            slot = up;
         end else begin
            climbing = 1'b0;
         end
      end
      heap_keys[slot] = key;
      held++;
   endfunction

   // last key goes to the root and sinks, left child wins a tie
   function automatic key_type pop_min();
      key_type     top;
      key_type     moved;
      int unsigned slot;
      int unsigned kid;
      bit          sinking;
      top     = heap_keys[0];
      held--;
      moved   = heap_keys[held];
      slot    = 0;
      sinking = 1'b1;
      while (sinking && 2 * slot + 1 < held) begin
         kid = 2 * slot + 1;
         if (kid + 1 < held && heap_keys[kid] > heap_keys[kid + 1])
            kid++;
         if (moved > heap_keys[kid]) begin
            heap_keys[slot] = heap_keys[kid];
            slot = kid;
         end else begin
            sinking = 1'b0;
         end
      end
      heap_keys[slot] = moved;
      return top;
   endfunction

   function automatic heap_result_t predict(logic kind, key_type key);
      heap_result_t r;
      r.min_out = '0;
      r.status  = STATUS_OK;
      if (kind == KIND_INSERT) begin
         if (held >= cap_limit())
            r.status = STATUS_FULL;
         else
            push_key(key);
      end else if (held == 0) begin
         r.status = STATUS_EMPTY;
      end else begin
         r.min_out = pop_min();
      end
      r.count = count_type'(held);
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         held    = 0;
         cap_reg = CAPACITY_RESET;
         expected_q.delete();
      end else begin
         // a response never belongs to a request accepted at the same edge
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_q.size() == 0) begin
               report_error("response with no request outstanding");
            end else begin
               want = expected_q.pop_front();
               if (rsp_mon.min_out !== want.min_out)
                  report_error($sformatf("min_out got 0x%h expected 0x%h",
                                         rsp_mon.min_out, want.min_out));
               if (rsp_mon.status !== want.status)
                  report_error($sformatf("status got %0d expected %0d",
                                         rsp_mon.status, want.status));
               if (rsp_mon.count !== want.count)
                  report_error($sformatf("count got %0d expected %0d",
                                         rsp_mon.count, want.count));
            end
         end
         if (csr_mon.valid && csr_mon.ready)
            cap_reg = csr_mon.capacity;
         if (req_mon.valid && req_mon.ready)
            expected_q.push_back(predict(req_mon.kind, req_mon.key_in));
      end
      outstanding <= expected_q.size();
   end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
   import bmhq_pkg::*;

   localparam int      DEPTH       = 1024;
   localparam int      IDLE_LIMIT  = 4000;
   localparam int      HOLD_CYCLES = 600;
   localparam key_type KEY_MAX     = key_type'(32'h7FFF_FFFF);
   localparam key_type KEY_MIN     = key_type'(32'h8000_0000);

   logic clock;
   logic reset;
   int   fail_count;
   int   waiting;
   int   quiet_cycles = 0;
   bit   req_idle_on  = 1'b0;
   bit   rsp_idle_on  = 1'b0;
   bit   hold_rsp     = 1'b0;

   bmhq_req_if req_chan ();
   bmhq_rsp_if rsp_chan ();
   bmhq_csr_if csr_chan ();

   binary_min_heap_queue #(.DEPTH(DEPTH)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   heap_checker #(.DEPTH(DEPTH)) heap_check (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_chan),
      .rsp_mon    (rsp_chan),
      .csr_mon    (csr_chan),
      .fail_count (fail_count),
      .waiting    (waiting)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)
          || (csr_chan.valid && csr_chan.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      wait (quiet_cycles >= IDLE_LIMIT);
      $display("** binary_min_heap_queue: FAILED **");
      $finish;
   end

   // mostly short gaps, now and then a long one
   function automatic int pick_gap(int floor_len);
      int r;
      r = $urandom_range(0, 99);
      if (r < 55)
         return floor_len;
      else if (r < 85)
         return $urandom_range(1, 3);
      else if (r < 97)
         return $urandom_range(4, 12);
      else
         return $urandom_range(20, 80);
   endfunction

   function automatic key_type random_key();
      case ($urandom_range(0, 7))
         0:       return key_type'(int'($urandom_range(0, 6)) - 3);
         1:       return ($urandom_range(0, 1) != 0) ? KEY_MAX : KEY_MIN;
         default: return key_type'($urandom());
      endcase
   endfunction

   // response side: random stalls, plus one long hold-off on request
   initial begin
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_rsp = 1'b0;
         end else if (rsp_idle_on && $urandom_range(0, 2) == 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (pick_gap(1)) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         @(posedge clock);
      end
   end

   task automatic send_request(logic kind, key_type key);
      int gap;
      req_chan.valid  <= 1'b1;
      req_chan.kind   <= kind;
      req_chan.key_in <= key;
      do @(posedge clock); while (!req_chan.ready);
      if (req_idle_on) begin
         gap = pick_gap(0);
         if (gap > 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // stop offering requests until every response is back
   task automatic drain();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (waiting != 0);
   endtask

   task automatic write_capacity(count_type value);
      csr_chan.valid    <= 1'b1;
      csr_chan.capacity <= value;
      do @(posedge clock); while (!csr_chan.ready);
      csr_chan.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic run_mix(int n, int delete_pct);
      for (int i = 0; i < n; i++)
         send_request(($urandom_range(0, 99) < delete_pct) ? KIND_DELETE : KIND_INSERT,
                      random_key());
   endtask

   task automatic shuffle_idle();
      req_idle_on = ($urandom_range(0, 3) != 0);
      rsp_idle_on = ($urandom_range(0, 3) != 0);
   endtask

   initial begin
      reset             <= 1'b1;
      req_chan.valid    <= 1'b0;
      req_chan.kind     <= KIND_INSERT;
      req_chan.key_in   <= '0;
      csr_chan.valid    <= 1'b0;
      csr_chan.capacity <= CAPACITY_RESET;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // delete from empty, extreme keys, ties, drain past empty
      send_request(KIND_DELETE, KEY_MAX);
      send_request(KIND_INSERT, KEY_MAX);
      send_request(KIND_INSERT, KEY_MIN);
      send_request(KIND_INSERT, '0);
      send_request(KIND_INSERT, '1);
      send_request(KIND_INSERT, key_type'(5));
      send_request(KIND_INSERT, key_type'(5));
      repeat (7) send_request(KIND_DELETE, '1);

      // zero capacity refuses everything
      drain();
      write_capacity('0);
      send_request(KIND_INSERT, key_type'(42));
      send_request(KIND_DELETE, '0);

      drain();
      write_capacity(count_type'(1));
      send_request(KIND_INSERT, key_type'(-7));
      send_request(KIND_INSERT, key_type'(9));
      send_request(KIND_DELETE, '0);

      // all-ones capacity clamps to the array size
      drain();
      write_capacity('1);
      send_request(KIND_INSERT, key_type'(3));
      send_request(KIND_INSERT, key_type'(8));
      send_request(KIND_INSERT, key_type'(-2));
      send_request(KIND_INSERT, key_type'(11));

      // capacity dropped below the fill level
      drain();
      write_capacity(count_type'(2));
      send_request(KIND_INSERT, key_type'(1));
      send_request(KIND_DELETE, '0);
      send_request(KIND_DELETE, '0);
      send_request(KIND_INSERT, key_type'(1));

      // small capacities, fill often above the new limit
      for (int r = 0; r < 4; r++) begin
         drain();
         write_capacity(count_type'($urandom_range(1, 12)));
         shuffle_idle();
         run_mix(30, 45);
      end

      // long response hold-off while requests keep coming
      drain();
      write_capacity(CAPACITY_RESET);
      req_idle_on = 1'b0;
      hold_rsp    = 1'b1;
      run_mix(100, 40);

      // fill the whole array, first stretch with no idling at all
      drain();
      write_capacity('1);
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      run_mix(500, 0);
      shuffle_idle();
      run_mix(530, 0);

      // deep deletes with capacity below fill
      drain();
      write_capacity(count_type'(700));
      shuffle_idle();
      run_mix(80, 50);

      drain();
      repeat (40) @(posedge clock);
      if (fail_count == 0 && waiting == 0)
         $display("** binary_min_heap_queue: PASSED **");
      else
         $display("** binary_min_heap_queue: FAILED **");
      $finish;
   end

endmodule
